// File: hdl/crf_pkg.sv
// shared types and constants of the clipped rectangle fill engine
package crf_pkg;

  localparam int WIDTH_W  = 9;
  localparam int HEIGHT_W = 8;
  localparam int ROW_W    = WIDTH_W + HEIGHT_W;
  localparam int CORNER_W = 18;
  localparam int COLOR_W  = 32;

  localparam logic [1:0] FUNC_CLEAR      = 2'd0;
  localparam logic [1:0] FUNC_PIXEL_RECT = 2'd1;
  localparam logic [1:0] FUNC_WORLD_RECT = 2'd2;
  localparam logic [1:0] FUNC_READ       = 2'd3;

  localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;

  localparam int QUEUE_DEPTH = 2;

  typedef logic signed [CORNER_W-1:0] corner_t;

  typedef struct packed {
    logic                is_read;
    logic                outside;
    logic [WIDTH_W-1:0]  sx;
    logic [WIDTH_W-1:0]  ex;
    logic [HEIGHT_W-1:0] sy;
    logic [HEIGHT_W-1:0] ey;
    logic [ROW_W-1:0]    row_base;
    logic [COLOR_W-1:0]  color;
  } crf_desc_t;

endpackage

// File: hdl/crf_front.sv
// command front end: world transform, sort and clip, descriptor build
module crf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    func_i,
  input  logic signed [15:0]            coord_a_x_i,
  input  logic signed [15:0]            coord_a_y_i,
  input  logic signed [15:0]            coord_b_x_i,
  input  logic signed [15:0]            coord_b_y_i,
  input  logic [crf_pkg::COLOR_W-1:0]   fill_color_i,
  input  logic [crf_pkg::WIDTH_W-1:0]   eff_width_i,
  input  logic [crf_pkg::HEIGHT_W-1:0]  eff_height_i,
  output logic                          push_o,
  output crf_pkg::crf_desc_t            desc_o,
  input  logic                          full_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ABS,
    S_DIV,
    S_CLIP,
    S_PUSH
  } state_e;

  localparam int DIV_SHIFT   = 10;
  localparam int DVD_W       = 17;
  localparam int QUO_W       = 13;
  localparam int RECIP_SHIFT = 22;
  localparam int PROD_W      = 35;
  localparam int DIVISOR     = 25;
  localparam int HALF_SCALE  = 12800;
  localparam logic [PROD_W-1:0] RECIP = PROD_W'(167773);

  state_e                          state_q;
  logic                            is_read_q;
  logic signed [15:0]              ax_q, ay_q, bx_q, by_q;
  logic [crf_pkg::COLOR_W-1:0]     color_q;
  crf_pkg::corner_t                cx_q [2];
  crf_pkg::corner_t                cy_q [2];
  logic [1:0]                      k_q;
  logic signed [27:0]              prod_q;
  logic [DVD_W-1:0]                dvd_q;
  logic                            neg_q;
  logic                            outside_q;
  logic [crf_pkg::WIDTH_W-1:0]     sx_q, ex_q;
  logic [crf_pkg::HEIGHT_W-1:0]    sy_q, ey_q;

  logic                            accept;
  logic [12:0]                     w_nine, h_sixteen;
  logic [crf_pkg::WIDTH_W-1:0]     extent, offset;
  logic signed [16:0]              op_a, op_b, diff;
  logic signed [27:0]              d_w, e_w, o_w, prod_d;
  logic [27:0]                     mag;
  logic [PROD_W-1:0]               recip_prod;
  logic [QUO_W-1:0]                quo;
  crf_pkg::corner_t                corner_n;
  crf_pkg::corner_t                lo_x, hi_x, lo_y, hi_y;
  logic                            rd_out;

  function automatic logic [crf_pkg::WIDTH_W-1:0] clip_to(
    crf_pkg::corner_t v, logic [crf_pkg::WIDTH_W-1:0] hi);
    crf_pkg::corner_t hi_s;
    hi_s = $signed({{(crf_pkg::CORNER_W-crf_pkg::WIDTH_W){1'b0}}, hi});
    if (v < 0) begin
      return '0;
    end else if (v > hi_s) begin
      return hi;
    end
    return v[crf_pkg::WIDTH_W-1:0];
  endfunction

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  // extent selection and world operand
  assign w_nine    = 13'(eff_width_i) * 13'd9;
  assign h_sixteen = 13'(eff_height_i) * 13'd16;
  assign extent    = (w_nine > h_sixteen) ? {1'b0, eff_height_i} : eff_width_i;
  assign offset    = k_q[1] ? {1'b0, eff_height_i} : eff_width_i;
  assign op_a      = k_q[1] ? 17'(ay_q) : 17'(ax_q);
  assign op_b      = k_q[1] ? 17'(by_q) : 17'(bx_q);
  assign diff      = k_q[0] ? (op_a + op_b) : (op_a - op_b);
  assign d_w       = 28'(diff);
  assign e_w       = $signed({19'b0, extent});
  assign o_w       = $signed({19'b0, offset});
  assign prod_d    = d_w * e_w + o_w * 28'(HALF_SCALE);
  assign mag       = prod_q[27] ? 28'(-prod_q) : prod_q;

  // divide by the odd factor through its reciprocal
  assign recip_prod = PROD_W'(dvd_q) * RECIP;
  assign quo        = recip_prod[RECIP_SHIFT +: QUO_W];
  assign corner_n   = neg_q ? -$signed({{(crf_pkg::CORNER_W-QUO_W){1'b0}}, quo}) :
                              $signed({{(crf_pkg::CORNER_W-QUO_W){1'b0}}, quo});

  // sort and clip
  assign lo_x   = (cx_q[0] <= cx_q[1]) ? cx_q[0] : cx_q[1];
  assign hi_x   = (cx_q[0] <= cx_q[1]) ? cx_q[1] : cx_q[0];
  assign lo_y   = (cy_q[0] <= cy_q[1]) ? cy_q[0] : cy_q[1];
  assign hi_y   = (cy_q[0] <= cy_q[1]) ? cy_q[1] : cy_q[0];
  assign rd_out = (ax_q < 0) || (ax_q >= $signed({7'b0, eff_width_i})) ||
                  (ay_q < 0) || (ay_q >= $signed({8'b0, eff_height_i}));

  assign push_o = (state_q == S_PUSH) && !full_i;

  always_comb begin
    desc_o          = '0;
    desc_o.is_read  = is_read_q;
    desc_o.outside  = outside_q;
    desc_o.sx       = sx_q;
    desc_o.ex       = ex_q;
    desc_o.sy       = sy_q;
    desc_o.ey       = ey_q;
    desc_o.row_base = crf_pkg::ROW_W'(sy_q) * crf_pkg::ROW_W'(eff_width_i);
    desc_o.color    = color_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            ax_q      <= coord_a_x_i;
            ay_q      <= coord_a_y_i;
            bx_q      <= coord_b_x_i;
            by_q      <= coord_b_y_i;
            color_q   <= fill_color_i;
            is_read_q <= (func_i == crf_pkg::FUNC_READ);
            k_q       <= '0;
            unique case (func_i)
              crf_pkg::FUNC_CLEAR: begin
                cx_q[0] <= '0;
                cx_q[1] <= $signed({9'b0, eff_width_i});
                cy_q[0] <= '0;
                cy_q[1] <= $signed({10'b0, eff_height_i});
                state_q <= S_CLIP;
              end
              crf_pkg::FUNC_PIXEL_RECT: begin
                cx_q[0] <= crf_pkg::CORNER_W'(coord_a_x_i);
                cx_q[1] <= crf_pkg::CORNER_W'(coord_b_x_i);
                cy_q[0] <= crf_pkg::CORNER_W'(coord_a_y_i);
                cy_q[1] <= crf_pkg::CORNER_W'(coord_b_y_i);
                state_q <= S_CLIP;
              end
              crf_pkg::FUNC_WORLD_RECT: begin
                state_q <= S_MUL;
              end
              crf_pkg::FUNC_READ: begin
                state_q <= S_CLIP;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_MUL: begin
          prod_q  <= prod_d;
          state_q <= S_ABS;
        end
        S_ABS: begin
          neg_q   <= prod_q[27];
          dvd_q   <= mag[DIV_SHIFT+DVD_W-1:DIV_SHIFT];
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (k_q[1]) begin
            cy_q[k_q[0]] <= corner_n;
          end else begin
            cx_q[k_q[0]] <= corner_n;
          end
          k_q     <= k_q + 2'd1;
          state_q <= (k_q == 2'd3) ? S_CLIP : S_MUL;
        end
        S_CLIP: begin
          if (is_read_q) begin
            outside_q <= rd_out;
            sx_q      <= ax_q[crf_pkg::WIDTH_W-1:0];
            ex_q      <= ax_q[crf_pkg::WIDTH_W-1:0];
            sy_q      <= ay_q[crf_pkg::HEIGHT_W-1:0];
            ey_q      <= ay_q[crf_pkg::HEIGHT_W-1:0];
          end else begin
            outside_q <= 1'b0;
            sx_q      <= clip_to(lo_x, eff_width_i);
            ex_q      <= clip_to(hi_x, eff_width_i);
            sy_q      <= crf_pkg::HEIGHT_W'(clip_to(lo_y, {1'b0, eff_height_i}));
            ey_q      <= crf_pkg::HEIGHT_W'(clip_to(hi_y, {1'b0, eff_height_i}));
          end
          state_q <= S_PUSH;
        end
        S_PUSH: begin
          if (!full_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("front not busy after accepting a command");

  a_div_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> ((int'(quo) * DIVISOR <= int'(dvd_q)) &&
                            (int'(dvd_q) < int'(quo) * DIVISOR + DIVISOR)))
    else $error("reciprocal divide off by one");

endmodule

// File: hdl/crf_queue.sv
// short descriptor queue between front end and pixel writer
module crf_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  crf_pkg::crf_desc_t push_desc_i,
  output logic               full_o,
  input  logic               pop_i,
  output crf_pkg::crf_desc_t head_o,
  output logic               empty_o
);

  localparam int PTR_W = $clog2(crf_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(crf_pkg::QUEUE_DEPTH + 1);

  crf_pkg::crf_desc_t entry_q [crf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q;

  assign full_o  = (cnt_q == CNT_W'(crf_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(crf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(crf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("descriptor queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("descriptor queue underflow");

endmodule

// File: hdl/crf_back.sv
// pixel writer and reader with the frame store
module crf_back #(
  parameter int FRAME_DEPTH = 76800
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [crf_pkg::WIDTH_W-1:0]  eff_width_i,
  input  crf_pkg::crf_desc_t           desc_i,
  input  logic                         empty_i,
  output logic                         pop_o,
  output logic                         done_o,
  output logic [crf_pkg::COLOR_W-1:0]  read_data_o,
  output logic                         read_outside_o
);

  typedef enum logic [1:0] {
    B_IDLE,
    B_FILL,
    B_RESP
  } state_e;

  localparam int ADDR_W = $clog2(FRAME_DEPTH);
  localparam int SUM_W  = crf_pkg::ROW_W + 1;

  logic [crf_pkg::COLOR_W-1:0]  mem [FRAME_DEPTH];
  logic [crf_pkg::COLOR_W-1:0]  mem_rdata_q;

  state_e                       state_q;
  logic [crf_pkg::WIDTH_W-1:0]  x_q, sx_q, ex_q;
  logic [crf_pkg::HEIGHT_W-1:0] y_q, ey_q;
  logic [crf_pkg::ROW_W-1:0]    row_q;
  logic [crf_pkg::COLOR_W-1:0]  color_q;
  logic                         done_q;
  logic [crf_pkg::COLOR_W-1:0]  rdata_q;
  logic                         outside_q;

  logic                         mem_we, mem_re;
  logic [SUM_W-1:0]             wr_sum, rd_sum;
  logic                         box_empty;

  assign pop_o     = (state_q == B_IDLE) && !empty_i;
  assign mem_we    = (state_q == B_FILL);
  assign mem_re    = pop_o && desc_i.is_read && !desc_i.outside;
  assign wr_sum    = SUM_W'(row_q) + SUM_W'(x_q);
  assign rd_sum    = SUM_W'(desc_i.row_base) + SUM_W'(desc_i.sx);
  assign box_empty = (desc_i.sx >= desc_i.ex) || (desc_i.sy >= desc_i.ey);

  assign done_o         = done_q;
  assign read_data_o    = rdata_q;
  assign read_outside_o = outside_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[ADDR_W'(wr_sum)] <= color_q;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[ADDR_W'(rd_sum)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      done_q    <= 1'b0;
      rdata_q   <= '0;
      outside_q <= 1'b0;
    end else begin
      done_q    <= 1'b0;
      rdata_q   <= '0;
      outside_q <= 1'b0;
      unique case (state_q)
        B_IDLE: begin
          if (pop_o) begin
            if (desc_i.is_read) begin
              if (desc_i.outside) begin
                done_q    <= 1'b1;
                outside_q <= 1'b1;
              end else begin
                state_q <= B_RESP;
              end
            end else if (box_empty) begin
              done_q <= 1'b1;
            end else begin
              x_q     <= desc_i.sx;
              sx_q    <= desc_i.sx;
              ex_q    <= desc_i.ex;
              y_q     <= desc_i.sy;
              ey_q    <= desc_i.ey;
              row_q   <= desc_i.row_base;
              color_q <= desc_i.color;
              state_q <= B_FILL;
            end
          end
        end
        B_FILL: begin
          if (x_q + 1'b1 == ex_q) begin
            if (y_q + 1'b1 == ey_q) begin
              done_q  <= 1'b1;
              state_q <= B_IDLE;
            end else begin
              y_q   <= y_q + 1'b1;
              row_q <= row_q + crf_pkg::ROW_W'(eff_width_i);
              x_q   <= sx_q;
            end
          end else begin
            x_q <= x_q + 1'b1;
          end
        end
        B_RESP: begin
          done_q  <= 1'b1;
          rdata_q <= mem_rdata_q;
          state_q <= B_IDLE;
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (int'(wr_sum) < FRAME_DEPTH))
    else $error("frame store write address out of range");

  a_fill_inside_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_FILL) |-> ((x_q < ex_q) && (y_q < ey_q)))
    else $error("fill walker left its rectangle");

endmodule

// File: hdl/clipped_rect_fill_engine_core.sv
// top level of the clipped rectangle fill engine
// A command is taken when start_i is high and busy_o is low; each command gives exactly
// one result, shown on read_data_o and read_outside_o for the single cycle in which
// done_o is high, and the receiver cannot hold it off. The front end takes a clear,
// pixel rectangle or read through its clip and push states, and a world rectangle
// first through multiply, absolute and divide states for each corner value, then hands
// the command to a two-entry queue, so it can take the next command while the writer
// is still busy. The writer has one memory port and writes one pixel per cycle, and a
// read fetches its pixel as it leaves the queue. The frame store has no reset.
module clipped_rect_fill_engine_core #(
  parameter int MAX_WIDTH  = 320,
  parameter int MAX_HEIGHT = 240
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   func_i,
  input  logic signed [15:0]           coord_a_x_i,
  input  logic signed [15:0]           coord_a_y_i,
  input  logic signed [15:0]           coord_b_x_i,
  input  logic signed [15:0]           coord_b_y_i,
  input  logic [crf_pkg::COLOR_W-1:0]  fill_color_i,
  output logic                         done_o,
  output logic [crf_pkg::COLOR_W-1:0]  read_data_o,
  output logic                         read_outside_o,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [crf_pkg::WIDTH_W-1:0]  cfg_wdata_i
);

  localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  logic [crf_pkg::WIDTH_W-1:0]  screen_width_q;
  logic [crf_pkg::HEIGHT_W-1:0] screen_height_q;
  logic [crf_pkg::WIDTH_W-1:0]  eff_width;
  logic [crf_pkg::HEIGHT_W-1:0] eff_height;

  logic                         push, full, pop, empty;
  crf_pkg::crf_desc_t           push_desc, head_desc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= 9'd320;
      screen_height_q <= 8'd240;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        crf_pkg::CFG_SCREEN_WIDTH: begin
          screen_width_q <= cfg_wdata_i;
        end
        crf_pkg::CFG_SCREEN_HEIGHT: begin
          screen_height_q <= cfg_wdata_i[crf_pkg::HEIGHT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign eff_width  = (int'(screen_width_q) > MAX_WIDTH) ?
                      crf_pkg::WIDTH_W'(MAX_WIDTH) : screen_width_q;
  assign eff_height = (int'(screen_height_q) > MAX_HEIGHT) ?
                      crf_pkg::HEIGHT_W'(MAX_HEIGHT) : screen_height_q;

  crf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .func_i       (func_i),
    .coord_a_x_i  (coord_a_x_i),
    .coord_a_y_i  (coord_a_y_i),
    .coord_b_x_i  (coord_b_x_i),
    .coord_b_y_i  (coord_b_y_i),
    .fill_color_i (fill_color_i),
    .eff_width_i  (eff_width),
    .eff_height_i (eff_height),
    .push_o       (push),
    .desc_o       (push_desc),
    .full_i       (full)
  );

  crf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head_desc),
    .empty_o     (empty)
  );

  crf_back #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .eff_width_i    (eff_width),
    .desc_i         (head_desc),
    .empty_i        (empty),
    .pop_o          (pop),
    .done_o         (done_o),
    .read_data_o    (read_data_o),
    .read_outside_o (read_outside_o)
  );

endmodule

// File: bench/clipped_rect_fill_engine_core_test.sv
// self-checking bench for the clipped rectangle fill engine: commands, screen sizes, reads
`timescale 1ns / 1ps

module clipped_rect_fill_engine_core_test;

  localparam int MAX_W = 320;
  localparam int MAX_H = 240;
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;
  localparam int N_PHASES = 11;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start_i;
  logic                         busy_o;
  logic [1:0]                   func_i;
  logic signed [15:0]           coord_a_x_i;
  logic signed [15:0]           coord_a_y_i;
  logic signed [15:0]           coord_b_x_i;
  logic signed [15:0]           coord_b_y_i;
  logic [crf_pkg::COLOR_W-1:0]  fill_color_i;
  logic                         done_o;
  logic [crf_pkg::COLOR_W-1:0]  read_data_o;
  logic                         read_outside_o;
  logic                         cfg_we_i;
  logic [1:0]                   cfg_idx_i;
  logic [crf_pkg::WIDTH_W-1:0]  cfg_wdata_i;

  typedef struct {
    logic [crf_pkg::COLOR_W-1:0] data;
    logic                        outside;
    longint                      stamp;
  } pixel_reply_t;

  class frame_scoreboard;
    logic [crf_pkg::COLOR_W-1:0] frame_mem [MAX_W*MAX_H];
    int unsigned                 scr_w = 320;
    int unsigned                 scr_h = 240;
    pixel_reply_t                pending_replies[$];
    int                          errors;
    int                          commands_seen;
    int                          replies_checked;

    function longint eff_w();
      return (scr_w > MAX_W) ? MAX_W : scr_w;
    endfunction

    function longint eff_h();
      return (scr_h > MAX_H) ? MAX_H : scr_h;
    endfunction

    function longint clamp(longint v, longint hi);
      if (v < 0) return 0;
      return (v > hi) ? hi : v;
    endfunction

    function void write_reg(logic [1:0] idx, logic [crf_pkg::WIDTH_W-1:0] data);
      if (idx == crf_pkg::CFG_SCREEN_WIDTH) scr_w = data;
      else if (idx == crf_pkg::CFG_SCREEN_HEIGHT) scr_h = data[crf_pkg::HEIGHT_W-1:0];
    endfunction

    function void paint_box(longint xa, longint ya, longint xb, longint yb,
                            logic [crf_pkg::COLOR_W-1:0] color);
      longint w, h, sx, ex, sy, ey;
      w  = eff_w();
      h  = eff_h();
      sx = clamp((xa <= xb) ? xa : xb, w);
      ex = clamp((xa <= xb) ? xb : xa, w);
      sy = clamp((ya <= yb) ? ya : yb, h);
      ey = clamp((ya <= yb) ? yb : ya, h);
      for (longint y = sy; y < ey; y++)
        for (longint x = sx; x < ex; x++)
          frame_mem[y*w + x] = color;
    endfunction

    function void apply_command(logic [1:0] func, logic signed [15:0] ax,
                                logic signed [15:0] ay, logic signed [15:0] bx,
                                logic signed [15:0] by, logic [crf_pkg::COLOR_W-1:0] color);
      pixel_reply_t rep;
      longint w, h, ext, cx, cy, hx, hy;
      w = eff_w();
      h = eff_h();
      cx = ax;
      cy = ay;
      hx = bx;
      hy = by;
      rep.data = '0;
      rep.outside = 1'b0;
      rep.stamp = $time;
      case (func)
        crf_pkg::FUNC_CLEAR: begin
          for (longint i = 0; i < w*h; i++) frame_mem[i] = color;
        end
        crf_pkg::FUNC_PIXEL_RECT: begin
          paint_box(cx, cy, hx, hy, color);
        end
        crf_pkg::FUNC_WORLD_RECT: begin
          ext = (w*9 > h*16) ? h : w;
          paint_box(((cx - hx)*ext + w*12800) / 25600, ((cy - hy)*ext + h*12800) / 25600,
                    ((cx + hx)*ext + w*12800) / 25600, ((cy + hy)*ext + h*12800) / 25600,
                    color);
        end
        default: begin
          if (cx < 0 || cx >= w || cy < 0 || cy >= h) rep.outside = 1'b1;
          else rep.data = frame_mem[cy*w + cx];
        end
      endcase
      pending_replies.push_back(rep);
      commands_seen++;
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_reply(logic [crf_pkg::COLOR_W-1:0] data, logic outside);
      pixel_reply_t rep;
      if (pending_replies.size() == 0 || pending_replies[0].stamp == $time) begin
        report_mismatch("reply with no command waiting");
      end else begin
        rep = pending_replies.pop_front();
        replies_checked++;
        if (data !== rep.data)
          report_mismatch($sformatf("read_data %h, want %h", data, rep.data));
        if (outside !== rep.outside)
          report_mismatch($sformatf("read_outside %b, want %b", outside, rep.outside));
      end
    endtask
  endclass

  frame_scoreboard sb;
  bit              no_gaps;

  clipped_rect_fill_engine_core #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .func_i        (func_i),
    .coord_a_x_i   (coord_a_x_i),
    .coord_a_y_i   (coord_a_y_i),
    .coord_b_x_i   (coord_b_x_i),
    .coord_b_y_i   (coord_b_y_i),
    .fill_color_i  (fill_color_i),
    .done_o        (done_o),
    .read_data_o   (read_data_o),
    .read_outside_o(read_outside_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_reply(read_data_o, read_outside_o);
  end

  task automatic issue_command(input logic [1:0] func, input logic signed [15:0] ax,
                               input logic signed [15:0] ay, input logic signed [15:0] bx,
                               input logic signed [15:0] by,
                               input logic [crf_pkg::COLOR_W-1:0] color);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    func_i       <= func;
    coord_a_x_i  <= ax;
    coord_a_y_i  <= ay;
    coord_b_x_i  <= bx;
    coord_b_y_i  <= by;
    fill_color_i <= color;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.apply_command(func, ax, ay, bx, by, color);
  endtask

  // wait until every reply is back and the writer has gone quiet
  task automatic settle();
    start_i <= 1'b0;
    while (sb.pending_replies.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic set_screen(input int w, input int h, input logic [1:0] spare_idx);
    logic [crf_pkg::WIDTH_W-1:0] junk;
    junk = crf_pkg::WIDTH_W'($urandom);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= crf_pkg::CFG_SCREEN_WIDTH;
    cfg_wdata_i <= crf_pkg::WIDTH_W'(w);
    @(posedge clk_i);
    sb.write_reg(crf_pkg::CFG_SCREEN_WIDTH, crf_pkg::WIDTH_W'(w));
    cfg_idx_i   <= crf_pkg::CFG_SCREEN_HEIGHT;
    cfg_wdata_i <= crf_pkg::WIDTH_W'(h);
    @(posedge clk_i);
    sb.write_reg(crf_pkg::CFG_SCREEN_HEIGHT, crf_pkg::WIDTH_W'(h));
    cfg_idx_i   <= spare_idx;
    cfg_wdata_i <= junk;
    @(posedge clk_i);
    sb.write_reg(spare_idx, junk);
    cfg_we_i    <= 1'b0;
  endtask

  // wide screens keep every fill small so the run stays short
  task automatic random_command(input bit wide);
    logic [1:0]         func;
    logic signed [15:0] ax, ay, bx, by;
    int                 w, h, mode, span, half;
    w    = int'(sb.eff_w());
    h    = int'(sb.eff_h());
    func = 2'($urandom_range(0, 3));
    if (wide && func == crf_pkg::FUNC_CLEAR) func = crf_pkg::FUNC_PIXEL_RECT;
    mode = wide ? 1 : $urandom_range(0, 4);
    span = 60*256;
    half = wide ? 8*256 : 60*256;
    ax = 16'($urandom);
    ay = 16'($urandom);
    bx = 16'($urandom);
    by = 16'($urandom);
    if (mode != 0) begin
      case (func)
        crf_pkg::FUNC_PIXEL_RECT: begin
          ax = 16'(int'($urandom_range(0, w + 8)) - 4);
          ay = 16'(int'($urandom_range(0, h + 8)) - 4);
          bx = 16'(int'(ax) + int'($urandom_range(0, 48)) - 24);
          by = 16'(int'(ay) + int'($urandom_range(0, 48)) - 24);
        end
        crf_pkg::FUNC_WORLD_RECT: begin
          ax = 16'(int'($urandom_range(0, 2*span)) - span);
          ay = 16'(int'($urandom_range(0, 2*span)) - span);
          bx = 16'(int'($urandom_range(0, 2*half)) - half);
          by = 16'(int'($urandom_range(0, 2*half)) - half);
        end
        crf_pkg::FUNC_READ: begin
          ax = 16'(int'($urandom_range(0, w + 3)) - 2);
          ay = 16'(int'($urandom_range(0, h + 3)) - 2);
        end
        default: ;
      endcase
    end
    issue_command(func, ax, ay, bx, by, $urandom);
  endtask

  initial begin
    int phase_w [N_PHASES] = '{16, 1, 0, 7, 511, 320, 1, 0, 0, 0, 0};
    int phase_h [N_PHASES] = '{12, 1, 5, 0, 255, 1, 240, 0, 0, 0, 0};
    int phase_n [N_PHASES] = '{14, 8, 6, 6, 16, 8, 8, 9, 9, 9, 9};
    sb = new();
    rst_ni       <= 1'b0;
    start_i      <= 1'b0;
    func_i       <= crf_pkg::FUNC_CLEAR;
    coord_a_x_i  <= '0;
    coord_a_y_i  <= '0;
    coord_b_x_i  <= '0;
    coord_b_y_i  <= '0;
    fill_color_i <= '0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= crf_pkg::CFG_SCREEN_WIDTH;
    cfg_wdata_i  <= '0;
    no_gaps = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full clear first so every later read hits a written pixel
    issue_command(crf_pkg::FUNC_CLEAR, 0, 0, 0, 0, $urandom);
    issue_command(crf_pkg::FUNC_READ, 0, 0, 0, 0, $urandom);
    issue_command(crf_pkg::FUNC_READ, 319, 239, 0, 0, $urandom);
    issue_command(crf_pkg::FUNC_READ, -1, 5, 0, 0, $urandom);
    issue_command(crf_pkg::FUNC_READ, 320, 0, 0, 0, $urandom);
    issue_command(crf_pkg::FUNC_READ, 0, 240, 0, 0, $urandom);
    issue_command(crf_pkg::FUNC_READ, -32768, -32768, 0, 0, $urandom);
    issue_command(crf_pkg::FUNC_READ, 32767, 32767, 0, 0, $urandom);
    issue_command(crf_pkg::FUNC_PIXEL_RECT, 10, 5, 3, 1, $urandom);
    issue_command(crf_pkg::FUNC_READ, 3, 1, 0, 0, $urandom);
    issue_command(crf_pkg::FUNC_READ, 9, 4, 0, 0, $urandom);
    issue_command(crf_pkg::FUNC_READ, 10, 5, 0, 0, $urandom);
    issue_command(crf_pkg::FUNC_PIXEL_RECT, -32768, -32768, 32767, 32767, 32'hffff_ffff);
    issue_command(crf_pkg::FUNC_PIXEL_RECT, 5, 5, 5, 20, 32'h0000_0000);
    issue_command(crf_pkg::FUNC_WORLD_RECT, 0, 0, 2560, 2560, $urandom);
    issue_command(crf_pkg::FUNC_WORLD_RECT, -32768, -32768, 32767, 32767, $urandom);
    issue_command(crf_pkg::FUNC_WORLD_RECT, 32767, 32767, -32768, -32768, $urandom);
    issue_command(crf_pkg::FUNC_WORLD_RECT, -12900, 100, 300, -200, $urandom);
    issue_command(crf_pkg::FUNC_READ, 160, 120, 0, 0, $urandom);
    issue_command(crf_pkg::FUNC_READ, 128, 88, 0, 0, $urandom);
    issue_command(crf_pkg::FUNC_READ, 0, 119, 0, 0, $urandom);
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      if (phase_w[p] == 0 && phase_h[p] == 0) begin
        phase_w[p] = $urandom_range(1, 40);
        phase_h[p] = $urandom_range(1, 30);
      end
      set_screen(phase_w[p], phase_h[p], p[0] ? CFG_SPARE_B : CFG_SPARE_A);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < phase_n[p]; i++) random_command(phase_w[p] * phase_h[p] > 4096);
      settle();
    end

    $display("%0d commands over %0d screen settings, %0d replies checked",
             sb.commands_seen, N_PHASES + 1, sb.replies_checked);
    $display("clears, pixel and world fills, in and out of bounds reads; %0d mismatches",
             sb.errors);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: clipped_rect_fill_engine_core.f
hdl/crf_pkg.sv
hdl/crf_front.sv
hdl/crf_queue.sv
hdl/crf_back.sv
hdl/clipped_rect_fill_engine_core.sv
bench/clipped_rect_fill_engine_core_test.sv
